@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle, quiet during reset.
`define ASSERT_SAME(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle, quiet during reset.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after a condition, including the reset cycle.
`define ASSERT_NEXT_ALWAYS(label, clk, cond, cons, msg) \
  label: assert property (@(posedge clk) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/msd_pkg.sv @@
// Shared types, constants and field layout of the map stroke delta decoder.
package msd_pkg;

  // Default width of the stroke and point counters
  localparam int COUNT_BITS_DEF = 15;

  // Input field widths
  localparam int ORIGIN_W  = 21;
  localparam int SCOUNT_W  = 15;
  localparam int WORD_W    = 16;
  localparam int IN_DATA_W = 80;

  // Result field widths
  localparam int COORD_W    = 32;
  localparam int INDEX_W    = 15;
  localparam int OUT_DATA_W = 80;

  // Bit that marks a short stroke word
  localparam int SHORT_FLAG_BIT = 14;
  // Bias removed from a non-negative short dx byte
  localparam logic [COORD_W-1:0] DX_BIAS = 32'h0000_0040;

  // Item kind on the input tuser
  typedef enum logic {
    FUNC_HEADER = 1'b0,
    FUNC_DATA   = 1'b1
  } func_t;

  // Result kind on the output tuser
  typedef enum logic {
    ST_POINT = 1'b0,
    ST_STRAY = 1'b1
  } status_t;

  // Position inside a long stroke
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_DX_LO  = 2'd1,
    PH_DY_HI  = 2'd2,
    PH_DY_LO  = 2'd3
  } phase_t;

  // Restore bit 14 of a long-form high word from bit 15
  function automatic logic [WORD_W-1:0] restore_high(input logic [WORD_W-1:0] w);
    return {w[15], w[15], w[13:0]};
  endfunction

endpackage

@@ rtl/map_stroke_delta_decoder.sv @@
// Top level of the map stroke delta decoder: input register, decode and accumulate, result register.
//
//  channel | dir | tdata (low bit up)                                 | tuser  | tlast
//  s_*     | in  | lat_origin 21, lon_origin 21, stroke_count 15,     | func   | -
//          |     | data_word 16, zero fill to 80                      |        |
//  m_*     | out | lat_seconds 32, lon_seconds 32, point_index 15,    | status | last
//          |     | zero fill to 80                                    |        |
//
// One request per cycle sustained while the output side is ready; a result passes through the
// input register and the result register after its request is accepted.
// The decode path is one 32-bit add per coordinate between the input register and
// the result register; the stroke accumulators and counters update as the request leaves.
// rst is synchronous and clears the accumulators, counters, phase and both valid flags.
// A stalled output holds the result; the input register keeps taking a request while
// it drains, so s_tready falls only when both registers hold work.
module map_stroke_delta_decoder #(
  parameter int COUNT_BITS = msd_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // lat_origin[20:0], lon_origin[41:21], stroke_count[56:42], data_word[72:57], zero above
  input  logic [msd_pkg::IN_DATA_W-1:0]  s_tdata,
  // func[0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // lat_seconds[31:0], lon_seconds[63:32], point_index[78:64], zero above
  output logic [msd_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[0]
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import msd_pkg::*;

  // Input register
  logic                  in_valid;
  func_t                 in_func;
  logic [ORIGIN_W-1:0]   in_lat;
  logic [ORIGIN_W-1:0]   in_lon;
  logic [SCOUNT_W-1:0]   in_count;
  logic [WORD_W-1:0]     in_word;

  // Decoder state
  logic [COORD_W-1:0]    lat_acc, lat_acc_next;
  logic [COORD_W-1:0]    lon_acc, lon_acc_next;
  logic [COUNT_BITS-1:0] strokes_left, strokes_left_next;
  logic [COUNT_BITS-1:0] point_count, point_count_next;
  phase_t                phase, phase_next;
  logic [COORD_W-1:0]    held_dx, held_dx_next;
  logic [WORD_W-1:0]     held_dy_high, held_dy_high_next;

  // Result register
  logic                  out_valid;
  status_t               out_status;
  logic [COORD_W-1:0]    out_lat;
  logic [COORD_W-1:0]    out_lon;
  logic [INDEX_W-1:0]    out_index;
  logic                  out_last;

  // Decode results
  logic                  fire;
  logic                  emit;
  status_t               res_status;
  logic [COORD_W-1:0]    res_lat;
  logic [COORD_W-1:0]    res_lon;
  logic [INDEX_W-1:0]    res_index;
  logic                  res_last;
  logic [COUNT_BITS+SCOUNT_W-1:0] count_wide;
  logic [COUNT_BITS+INDEX_W-1:0]  index_wide;
  logic [COUNT_BITS-1:0] count_in;
  logic [COUNT_BITS-1:0] left_dec;
  logic [COUNT_BITS-1:0] count_inc;
  logic [7:0]            lo_byte;
  logic [7:0]            hi_byte;
  logic [COORD_W-1:0]    short_dx;
  logic [COORD_W-1:0]    short_dy;
  logic [COORD_W-1:0]    long_dy;

  // Handshake: the decode stage moves when the result register is free or draining
  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func  <= func_t'(s_tuser);
      in_lat   <= s_tdata[ORIGIN_W-1:0];
      in_lon   <= s_tdata[2*ORIGIN_W-1:ORIGIN_W];
      in_count <= s_tdata[2*ORIGIN_W+SCOUNT_W-1:2*ORIGIN_W];
      in_word  <= s_tdata[2*ORIGIN_W+SCOUNT_W+WORD_W-1:2*ORIGIN_W+SCOUNT_W];
    end
  end

  // Fit the stroke count to the counter width
  assign count_wide = {{COUNT_BITS{1'b0}}, in_count};
  assign count_in   = count_wide[COUNT_BITS-1:0];
  assign left_dec   = strokes_left - COUNT_BITS'(1);
  assign count_inc  = point_count + COUNT_BITS'(1);
  assign index_wide = {{INDEX_W{1'b0}}, count_inc};

  // Short stroke deltas
  assign lo_byte  = in_word[7:0];
  assign hi_byte  = in_word[15:8];
  assign short_dy = {{(COORD_W-8){lo_byte[7]}}, lo_byte};
  assign short_dx = hi_byte[7] ? {{(COORD_W-8){1'b1}}, hi_byte}
                               : {{(COORD_W-8){1'b0}}, hi_byte} - DX_BIAS;
  assign long_dy  = {held_dy_high, in_word};

  // Decode one request and work out the next state
  always_comb begin
    lat_acc_next      = lat_acc;
    lon_acc_next      = lon_acc;
    strokes_left_next = strokes_left;
    point_count_next  = point_count;
    phase_next        = phase;
    held_dx_next      = held_dx;
    held_dy_high_next = held_dy_high;
    emit              = 1'b0;
    res_status        = ST_POINT;
    res_lat           = '0;
    res_lon           = '0;
    res_index         = '0;
    res_last          = 1'b0;

    if (in_func == FUNC_HEADER) begin
      // Load the origin and emit it as point 0
      lat_acc_next      = {{(COORD_W-ORIGIN_W){in_lat[ORIGIN_W-1]}}, in_lat};
      lon_acc_next      = {{(COORD_W-ORIGIN_W){in_lon[ORIGIN_W-1]}}, in_lon};
      strokes_left_next = count_in;
      point_count_next  = '0;
      phase_next        = PH_START;
      emit              = 1'b1;
      res_lat           = lat_acc_next;
      res_lon           = lon_acc_next;
      res_last          = (count_in == '0);
    end else begin
      case (phase)
        PH_START: begin
          if (strokes_left == '0) begin
            // Drop a stray word
            emit       = 1'b1;
            res_status = ST_STRAY;
          end else if (in_word[SHORT_FLAG_BIT]) begin
            lat_acc_next = lat_acc + short_dy;
            lon_acc_next = lon_acc + short_dx;
            emit         = 1'b1;
          end else begin
            held_dx_next = {restore_high(in_word), {WORD_W{1'b0}}};
            phase_next   = PH_DX_LO;
          end
        end
        PH_DX_LO: begin
          held_dx_next = {held_dx[COORD_W-1:WORD_W], in_word};
          phase_next   = PH_DY_HI;
        end
        PH_DY_HI: begin
          held_dy_high_next = restore_high(in_word);
          phase_next        = PH_DY_LO;
        end
        PH_DY_LO: begin
          lat_acc_next = lat_acc + long_dy;
          lon_acc_next = lon_acc + held_dx;
          phase_next   = PH_START;
          emit         = 1'b1;
        end
        default: begin
          phase_next = PH_START;
        end
      endcase

      // Close a finished stroke
      if (emit && res_status == ST_POINT) begin
        strokes_left_next = left_dec;
        point_count_next  = count_inc;
        res_lat           = lat_acc_next;
        res_lon           = lon_acc_next;
        res_index         = index_wide[INDEX_W-1:0];
        res_last          = (left_dec == '0);
      end
    end
  end

  // Advance the decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_acc      <= '0;
      lon_acc      <= '0;
      strokes_left <= '0;
      point_count  <= '0;
      phase        <= PH_START;
    end else if (fire) begin
      lat_acc      <= lat_acc_next;
      lon_acc      <= lon_acc_next;
      strokes_left <= strokes_left_next;
      point_count  <= point_count_next;
      phase        <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_dx      <= held_dx_next;
      held_dy_high <= held_dy_high_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_status <= res_status;
      out_lat    <= res_lat;
      out_lon    <= res_lon;
      out_index  <= res_index;
      out_last   <= res_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-2*COORD_W-INDEX_W){1'b0}}, out_index, out_lon, out_lat};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

endmodule

@@ rtl/msd_checker.sv @@
// Port checker for the map stroke delta decoder and its bind.
`include "assert_macros.svh"

module msd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [msd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);
  import msd_pkg::*;

  logic stalled;
  logic stray;

  assign stalled = m_tvalid && !m_tready;
  assign stray   = m_tvalid && (m_tuser == ST_STRAY);

  // Keep a stalled result in place
  `ASSERT_NEXT(a_hold_valid, clk, rst, stalled, m_tvalid, "result dropped while stalled")
  `ASSERT_NEXT(a_hold_data, clk, rst, stalled, $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
  // A dropped word carries no point
  `ASSERT_SAME(a_stray_clean, clk, rst, stray, (m_tdata == '0) && !m_tlast, "stray result not cleared")
  // Reset leaves no result pending
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid, "result valid after reset")

endmodule

bind map_stroke_delta_decoder msd_checker u_msd_checker (.*);

@@ sim/map_stroke_delta_decoder_tb.sv @@
// Self-checking testbench for the map stroke delta decoder stream block.
`timescale 1ns / 100ps

module map_stroke_delta_decoder_tb;
  import msd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [WORD_W-1:0] SHORT_FLAG = 16'h1 << SHORT_FLAG_BIT;

  // One decoded point or stray notice as it leaves the block
  typedef struct packed {
    status_t            status;
    logic [COORD_W-1:0] lat;
    logic [COORD_W-1:0] lon;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } point_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  map_stroke_delta_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  point_t expected_points[$];
  int     mismatches = 0;
  int     requests_sent = 0;
  int     idle_cycles = 0;
  bit     src_pace_on = 1'b1;
  bit     sink_pace_on = 1'b1;
  bit     hold_off_req = 1'b0;
  int     hold_off_count = 0;
  int     sink_stall_left = 0;

  // Decoder state mirrored from the accepted requests
  logic [COORD_W-1:0] lat_sum = '0;
  logic [COORD_W-1:0] lon_sum = '0;
  logic [INDEX_W-1:0] strokes_due = '0;
  logic [INDEX_W-1:0] points_out = '0;
  phase_t             long_phase = PH_START;
  logic [COORD_W-1:0] long_dx = '0;
  logic [WORD_W-1:0]  long_dy_hi = '0;

  // Mostly short gaps, a few long ones
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Copy bit 15 into bit 14 of a long-form high word
  function automatic logic [WORD_W-1:0] with_sign_bit14(input logic [WORD_W-1:0] w);
    return w[15] ? (w | SHORT_FLAG) : (w & ~SHORT_FLAG);
  endfunction

  // Add one stroke to the running position and build its point
  function automatic point_t close_stroke(input logic [COORD_W-1:0] dx, dy);
    point_t pt;
    lat_sum = lat_sum + dy;
    lon_sum = lon_sum + dx;
    strokes_due = strokes_due - INDEX_W'(1);
    points_out = points_out + INDEX_W'(1);
    pt.status = ST_POINT;
    pt.lat = lat_sum;
    pt.lon = lon_sum;
    pt.idx = points_out;
    pt.last = (strokes_due == '0);
    return pt;
  endfunction

  // Advance the mirrored decoder by one request; return 1 when a result is due
  function automatic bit decode_request(input func_t kind, input logic [ORIGIN_W-1:0] lat0,
                                        input logic [ORIGIN_W-1:0] lon0,
                                        input logic [SCOUNT_W-1:0] cnt,
                                        input logic [WORD_W-1:0] word, output point_t pt);
    logic [COORD_W-1:0] dx, dy;
    pt = '0;
    if (kind == FUNC_HEADER) begin
      lat_sum = {{(COORD_W-ORIGIN_W){lat0[ORIGIN_W-1]}}, lat0};
      lon_sum = {{(COORD_W-ORIGIN_W){lon0[ORIGIN_W-1]}}, lon0};
      strokes_due = cnt;
      points_out = '0;
      long_phase = PH_START;
      pt.status = ST_POINT;
      pt.lat = lat_sum;
      pt.lon = lon_sum;
      pt.last = (cnt == '0);
      return 1'b1;
    end
    case (long_phase)
      PH_START: begin
        // Nothing left in the segment: drop the word and flag it
        if (strokes_due == '0) begin
          pt.status = ST_STRAY;
          return 1'b1;
        end
        if (word[SHORT_FLAG_BIT]) begin
          dy = {{24{word[7]}}, word[7:0]};
          dx = word[15] ? {24'hFF_FFFF, word[15:8]} : {24'h0, word[15:8]} - DX_BIAS;
          pt = close_stroke(dx, dy);
          return 1'b1;
        end
        long_dx = {with_sign_bit14(word), 16'h0};
        long_phase = PH_DX_LO;
        return 1'b0;
      end
      PH_DX_LO: begin
        long_dx[15:0] = word;
        long_phase = PH_DY_HI;
        return 1'b0;
      end
      PH_DY_HI: begin
        long_dy_hi = with_sign_bit14(word);
        long_phase = PH_DY_LO;
        return 1'b0;
      end
      default: begin
        long_phase = PH_START;
        pt = close_stroke(long_dx, {long_dy_hi, word});
        return 1'b1;
      end
    endcase
  endfunction

  // Offer one request, hold it until accepted, then record what it should produce
  task automatic send_request(input func_t kind, input logic [ORIGIN_W-1:0] lat0,
                              input logic [ORIGIN_W-1:0] lon0,
                              input logic [SCOUNT_W-1:0] cnt, input logic [WORD_W-1:0] word);
    int gap;
    point_t pt;
    gap = src_pace_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {{(IN_DATA_W-ORIGIN_W*2-SCOUNT_W-WORD_W){1'b0}}, word, cnt, lon0, lat0};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (decode_request(kind, lat0, lon0, cnt, word, pt)) expected_points.push_back(pt);
    requests_sent++;
  endtask

  // Headers carry junk in the word field, data items junk in the header fields
  task automatic send_header(input logic [ORIGIN_W-1:0] lat0, lon0,
                             input logic [SCOUNT_W-1:0] cnt);
    send_request(FUNC_HEADER, lat0, lon0, cnt, WORD_W'($urandom));
  endtask

  task automatic send_word(input logic [WORD_W-1:0] word);
    send_request(FUNC_DATA, ORIGIN_W'($urandom), ORIGIN_W'($urandom), SCOUNT_W'($urandom),
                 word);
  endtask

  function logic [ORIGIN_W-1:0] rand_origin();
    int v;
    v = $urandom_range(0, 1296000) - 648000;
    return v[ORIGIN_W-1:0];
  endfunction

  // Send the first words of a long stroke; the opening word has the short flag clear
  task automatic send_long_words(input int words);
    for (int k = 0; k < words; k++) begin
      if (k == 0) send_word(16'($urandom) & ~SHORT_FLAG);
      else send_word(16'($urandom));
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_points.size() != 0);
  endtask

  // Stray words before any header and after an empty segment, origin extremes
  task automatic test_empty_segments();
    send_word(16'hFFFF);
    send_header(ORIGIN_W'(-648000), ORIGIN_W'(648000), SCOUNT_W'(0));
    send_word(16'h0000);
    send_header(ORIGIN_W'(648000), ORIGIN_W'(-648000), SCOUNT_W'(0));
  endtask

  // Short strokes over both dx forms and the byte extremes, then a stray word
  task automatic test_short_strokes();
    send_header(ORIGIN_W'(0), ORIGIN_W'(0), SCOUNT_W'(4));
    send_word(16'h7F7F);
    send_word(16'hC080);
    send_word(16'h4000);
    send_word(16'hFFFF);
    send_word(16'h5A5A);
  endtask

  // Long strokes with bit 14 restored both ways; the longitude returns to its origin
  task automatic test_long_strokes();
    send_header(ORIGIN_W'(648000), ORIGIN_W'(-648000), SCOUNT_W'(2));
    send_word(16'h8000);
    send_word(16'h0001);
    send_word(16'hBFFF);
    send_word(16'hFFFF);
    send_word(16'h3FFF);
    send_word(16'hFFFF);
    send_word(16'h7FFF);
    send_word(16'hFFFF);
  endtask

  // A header in the middle of a long stroke drops it; largest stroke count
  task automatic test_header_mid_stroke();
    send_header(ORIGIN_W'(0), ORIGIN_W'(0), SCOUNT_W'(2));
    send_word(16'h1234);
    send_word(16'hABCD);
    send_header(ORIGIN_W'(-1), ORIGIN_W'(1), SCOUNT_W'(1));
    send_word(16'h41FE);
    send_header(ORIGIN_W'(123), ORIGIN_W'(-456), SCOUNT_W'(32767));
    send_word(16'hFF01);
  endtask

  // Mostly whole segments with random content, some cut short, some stray words
  task automatic test_random_segments(input int target);
    logic [SCOUNT_W-1:0] cnt;
    int  n;
    int  words;
    bit  whole;
    while (requests_sent < target) begin
      if ($urandom_range(0, 99) < 6) begin
        cnt = SCOUNT_W'($urandom_range(9, 32767));
        n = $urandom_range(1, 6);
      end else begin
        cnt = SCOUNT_W'($urandom_range(0, 8));
        n = int'(cnt);
      end
      whole = 1'b1;
      send_header(rand_origin(), rand_origin(), cnt);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 55) begin
          send_word(16'($urandom) | SHORT_FLAG);
        end else begin
          words = ($urandom_range(0, 99) < 4) ? $urandom_range(1, 3) : 4;
          send_long_words(words);
          if (words < 4) begin
            whole = 1'b0;
            break;
          end
        end
      end
      if (whole && n == int'(cnt) && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 2)) send_word(16'($urandom));
      end
    end
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_output_stall();
    src_pace_on = 1'b0;
    sink_pace_on = 1'b0;
    hold_off_req = 1'b1;
    send_header(rand_origin(), rand_origin(), SCOUNT_W'(40));
    repeat (20) send_word(16'($urandom) | SHORT_FLAG);
    repeat (5) send_long_words(4);
    src_pace_on = 1'b1;
    sink_pace_on = 1'b1;
  endtask

  // Drive the output ready: a requested long hold-off, else random stalls
  always @(posedge clk) begin
    if (hold_off_req) begin
      m_tready <= 1'b0;
      if (hold_off_count == HOLD_OFF_CYCLES) begin
        hold_off_req = 1'b0;
        hold_off_count = 0;
      end else begin
        hold_off_count++;
      end
    end else if (sink_stall_left > 0) begin
      m_tready <= 1'b0;
      sink_stall_left--;
    end else if (sink_pace_on) begin
      sink_stall_left = pick_gap();
      m_tready <= (sink_stall_left == 0);
      if (sink_stall_left > 0) sink_stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function void check_field(input string name, input logic [COORD_W-1:0] want, got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every accepted result with the oldest expected point
  always @(posedge clk) begin
    point_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result: status %0b lat %0h lon %0h", m_tuser, m_tdata[31:0],
               m_tdata[63:32]);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        check_field("status", COORD_W'(want.status), COORD_W'(m_tuser));
        check_field("lat_seconds", want.lat, m_tdata[31:0]);
        check_field("lon_seconds", want.lon, m_tdata[63:32]);
        check_field("point_index", COORD_W'(want.idx), COORD_W'(m_tdata[78:64]));
        check_field("last", COORD_W'(want.last), COORD_W'(m_tlast));
      end
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_segments();
    test_short_strokes();
    test_long_strokes();
    test_header_mid_stroke();
    test_random_segments(requests_sent + 540);
    src_pace_on = 1'b0;
    sink_pace_on = 1'b0;
    test_random_segments(requests_sent + 60);
    src_pace_on = 1'b1;
    sink_pace_on = 1'b1;
    test_output_stall();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
